/* sv/se2_pose_transform_unit_defines.svh */
// Shared assertion macros for the pose transform unit.
// SE2PT_ASSERT expects signals named clk and rst_n in the including scope; SE2PT_ASSERT_ALWAYS needs only clk.
`ifndef SE2_POSE_TRANSFORM_UNIT_DEFINES_SVH
`define SE2_POSE_TRANSFORM_UNIT_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define SE2PT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SE2PT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/se2pt_pkg.sv */
package se2pt_pkg;

    // Default sizes of the position and heading fields.
    localparam int DEF_COORD_BITS = 32;
    localparam int DEF_ANGLE_BITS = 16;

    // CORDIC: 30 iterations in signed Q2.30, angles in 32-bit binary units.
    localparam int CORDIC_STEPS = 30;
    localparam int CS_W         = 33;
    localparam int Z_W          = 34;
    localparam int CORDIC_GAIN  = 652032874;

    // Products are in Q2.30 times the position format.
    localparam int ROUND_SHIFT = 30;

    // Operation codes.
    localparam logic [1:0] OP_COMPOSE = 2'd0;
    localparam logic [1:0] OP_INVERT  = 2'd1;
    localparam logic [1:0] OP_POINT   = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // Arctangent of 2^-idx in 32-bit binary angle units.
    function automatic logic [31:0] arc_of(input int idx);
        logic [31:0] arc;
        case (idx)
            0:       arc = 32'h20000000;
            1:       arc = 32'h12E4051E;
            2:       arc = 32'h09FB385B;
            3:       arc = 32'h051111D4;
            4:       arc = 32'h028B0D43;
            5:       arc = 32'h0145D7E1;
            6:       arc = 32'h00A2F61E;
            7:       arc = 32'h00517C55;
            8:       arc = 32'h0028BE53;
            9:       arc = 32'h00145F2F;
            10:      arc = 32'h000A2F98;
            11:      arc = 32'h000517CC;
            12:      arc = 32'h00028BE6;
            13:      arc = 32'h000145F3;
            14:      arc = 32'h0000A2F9;
            15:      arc = 32'h0000517C;
            16:      arc = 32'h000028BE;
            17:      arc = 32'h0000145F;
            18:      arc = 32'h00000A2F;
            19:      arc = 32'h00000517;
            20:      arc = 32'h0000028B;
            21:      arc = 32'h00000145;
            22:      arc = 32'h000000A2;
            23:      arc = 32'h00000051;
            24:      arc = 32'h00000028;
            25:      arc = 32'h00000014;
            26:      arc = 32'h0000000A;
            27:      arc = 32'h00000005;
            28:      arc = 32'h00000002;
            29:      arc = 32'h00000001;
            default: arc = 32'h00000000;
        endcase
        return arc;
    endfunction

endpackage

/* sv/se2pt_cordic.sv */
module se2pt_cordic #(
    parameter int ANGLE_BITS = se2pt_pkg::DEF_ANGLE_BITS,
    parameter int SIDE_W     = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              in_valid,
    input  logic [ANGLE_BITS-1:0]             angle,
    input  logic [SIDE_W-1:0]                 in_side,
    output logic                              out_valid,
    output logic signed [se2pt_pkg::CS_W-1:0] cos_val,
    output logic signed [se2pt_pkg::CS_W-1:0] sin_val,
    output logic [SIDE_W-1:0]                 out_side
);
    import se2pt_pkg::*;

    // Stage 0 is the input register; stage i+1 holds the result of iteration i.
    logic                   valid_reg [0:CORDIC_STEPS];
    logic                   flip_reg  [0:CORDIC_STEPS];
    logic signed [CS_W-1:0] x_reg     [0:CORDIC_STEPS];
    logic signed [CS_W-1:0] y_reg     [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]  z_reg     [0:CORDIC_STEPS];
    logic [SIDE_W-1:0]      side_reg  [0:CORDIC_STEPS];

    logic signed [CS_W-1:0] x_next [1:CORDIC_STEPS];
    logic signed [CS_W-1:0] y_next [1:CORDIC_STEPS];
    logic signed [Z_W-1:0]  z_next [1:CORDIC_STEPS];

    logic                   last_valid_reg;
    logic signed [CS_W-1:0] cos_reg;
    logic signed [CS_W-1:0] sin_reg;
    logic [SIDE_W-1:0]      last_side_reg;

    logic [31:0]            wide_angle;
    logic                   flip_in;
    logic signed [Z_W-1:0]  z_in;

    // Widen the heading to 32 bits and fold the second and third quadrants
    // onto the first and fourth by removing a half turn.
    always_comb
    begin
        wide_angle = {angle, {(32 - ANGLE_BITS){1'b0}}};
        flip_in    = wide_angle[31] ^ wide_angle[30];
        z_in       = Z_W'($signed({wide_angle[31] ^ flip_in, wide_angle[30:0]}));
    end

    // One rotation step per stage, with floor shifts.
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [Z_W-1:0] arc;

        assign arc = $signed({{(Z_W - 32){1'b0}}, arc_of(i)});

        always_comb
        begin
            if (!z_reg[i][Z_W-1])
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - arc;
            end
            else
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + arc;
            end
        end
    end

    // Valid bits of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= CORDIC_STEPS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            last_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= CORDIC_STEPS; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
            last_valid_reg <= valid_reg[CORDIC_STEPS];
        end
    end

    // Data path registers, all moving together.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg[0]    <= CS_W'(CORDIC_GAIN);
            y_reg[0]    <= '0;
            z_reg[0]    <= z_in;
            flip_reg[0] <= flip_in;
            side_reg[0] <= in_side;
            for (int k = 1; k <= CORDIC_STEPS; k++)
            begin
                x_reg[k]    <= x_next[k];
                y_reg[k]    <= y_next[k];
                z_reg[k]    <= z_next[k];
                flip_reg[k] <= flip_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
            // Undo the half-turn fold.
            cos_reg       <= flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
            sin_reg       <= flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
            last_side_reg <= side_reg[CORDIC_STEPS];
        end
    end

    assign out_valid = last_valid_reg;
    assign cos_val   = cos_reg;
    assign sin_val   = sin_reg;
    assign out_side  = last_side_reg;

endmodule

/* sv/se2_pose_transform_unit.sv */
// Channel   Dir  tdata (low bit first)                              tuser
// s_axis    in   pose_x, pose_y, pose_angle, other_x, other_y,      op
//                other_angle
// m_axis    out  out_x, out_y, out_angle                            saturated
//
// One transfer per cycle in each direction while the output is not stalled; the
// path from input transfer to m_axis_tvalid runs through 36 register stages: the
// input register, the 30 CORDIC iteration stages, and the fold, coefficient,
// multiply, sum and output registers.
// Reset clears only the valid bits; data registers are not reset.
// A stalled output holds the whole pipeline and drops s_axis_tready.
module se2_pose_transform_unit #(
    parameter int COORD_BITS = se2pt_pkg::DEF_COORD_BITS,
    parameter int ANGLE_BITS = se2pt_pkg::DEF_ANGLE_BITS,
    parameter int IN_W  = ((4 * COORD_BITS + 2 * ANGLE_BITS + 7) / 8) * 8,
    parameter int OUT_W = ((2 * COORD_BITS + ANGLE_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // pose_x, pose_y, pose_angle, other_x, other_y, other_angle
    input  logic [IN_W-1:0]  s_axis_tdata,
    // op
    input  logic [1:0]       s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // out_x, out_y, out_angle
    output logic [OUT_W-1:0] m_axis_tdata,
    // saturated
    output logic [0:0]       m_axis_tuser
);
    import se2pt_pkg::*;

    localparam int L     = COORD_BITS / 2;
    localparam int H     = COORD_BITS - L;
    localparam int PH_W  = H + CS_W;
    localparam int PL_W  = L + 1 + CS_W;
    localparam int HI_W  = H + CS_W + 2;
    localparam int LO_W  = L + CS_W + 2;
    localparam int TOT_W = COORD_BITS + CS_W + 3;
    localparam int Q_W   = TOT_W - ROUND_SHIFT;
    localparam logic [TOT_W-1:0] ROUND_HALF = TOT_W'(1) << (ROUND_SHIFT - 1);

    typedef struct packed {
        logic                         invert;
        logic                         none;
        logic signed [COORD_BITS-1:0] a;
        logic signed [COORD_BITS-1:0] b;
        logic signed [COORD_BITS-1:0] base_x;
        logic signed [COORD_BITS-1:0] base_y;
        logic [ANGLE_BITS-1:0]        angle;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

    // Round-to-nearest result clipped to the position range: {clipped, value}.
    function automatic logic [COORD_BITS:0] clip_q(input logic [Q_W-1:0] q);
        logic ovf;
        logic [COORD_BITS-1:0] v;
        ovf = !((&q[Q_W-1:COORD_BITS-1]) || !(|q[Q_W-1:COORD_BITS-1]));
        if (!ovf)
        begin
            v = q[COORD_BITS-1:0];
        end
        else if (q[Q_W-1])
        begin
            v = {1'b1, {(COORD_BITS - 1){1'b0}}};
        end
        else
        begin
            v = {1'b0, {(COORD_BITS - 1){1'b1}}};
        end
        return {ovf, v};
    endfunction

    logic advance;

    logic [1:0]                   op;
    logic signed [COORD_BITS-1:0] pose_x;
    logic signed [COORD_BITS-1:0] pose_y;
    logic [ANGLE_BITS-1:0]        pose_angle;
    logic signed [COORD_BITS-1:0] other_x;
    logic signed [COORD_BITS-1:0] other_y;
    logic [ANGLE_BITS-1:0]        other_angle;
    side_t                        in_side;

    logic                   cs_valid;
    logic signed [CS_W-1:0] cos_val;
    logic signed [CS_W-1:0] sin_val;
    logic [SIDE_W-1:0]      cs_side_bits;
    side_t                  cs_side;

    logic                   coef_valid_reg;
    side_t                  coef_side_reg;
    logic signed [CS_W-1:0] kc_reg;
    logic signed [CS_W-1:0] ks_reg;
    logic signed [CS_W-1:0] kns_reg;

    logic signed [H-1:0]    a_hi;
    logic signed [H-1:0]    b_hi;
    logic signed [L:0]      a_lo;
    logic signed [L:0]      b_lo;

    logic                   mul_valid_reg;
    side_t                  mul_side_reg;
    logic signed [PH_W-1:0] px_ah_reg;
    logic signed [PL_W-1:0] px_al_reg;
    logic signed [PH_W-1:0] px_bh_reg;
    logic signed [PL_W-1:0] px_bl_reg;
    logic signed [PH_W-1:0] py_ah_reg;
    logic signed [PL_W-1:0] py_al_reg;
    logic signed [PH_W-1:0] py_bh_reg;
    logic signed [PL_W-1:0] py_bl_reg;

    logic                   sum_valid_reg;
    side_t                  sum_side_reg;
    logic signed [HI_W-1:0] hi_x_reg;
    logic signed [LO_W-1:0] lo_x_reg;
    logic signed [HI_W-1:0] hi_y_reg;
    logic signed [LO_W-1:0] lo_y_reg;

    logic [TOT_W-1:0]      tot_x;
    logic [TOT_W-1:0]      tot_y;
    logic [COORD_BITS:0]   clip_x;
    logic [COORD_BITS:0]   clip_y;

    logic                  m_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic [ANGLE_BITS-1:0] out_angle_reg;
    logic                  sat_reg;

    // The whole pipeline moves unless a result is waiting to be taken.
    assign advance       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    // Unpack the input transfer.
    always_comb
    begin
        op          = s_axis_tuser;
        pose_x      = s_axis_tdata[COORD_BITS-1:0];
        pose_y      = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        pose_angle  = s_axis_tdata[2*COORD_BITS+ANGLE_BITS-1:2*COORD_BITS];
        other_x     = s_axis_tdata[3*COORD_BITS+ANGLE_BITS-1:2*COORD_BITS+ANGLE_BITS];
        other_y     = s_axis_tdata[4*COORD_BITS+ANGLE_BITS-1:3*COORD_BITS+ANGLE_BITS];
        other_angle = s_axis_tdata[4*COORD_BITS+2*ANGLE_BITS-1:4*COORD_BITS+ANGLE_BITS];
    end

    // Operand selection and the result heading, decided at the input.
    always_comb
    begin
        in_side.invert = (op == OP_INVERT);
        in_side.none   = (op == OP_NONE);
        case (op)
            OP_COMPOSE:
            begin
                in_side.a      = other_x;
                in_side.b      = other_y;
                in_side.base_x = pose_x;
                in_side.base_y = pose_y;
                in_side.angle  = pose_angle + other_angle;
            end
            OP_INVERT:
            begin
                in_side.a      = pose_x;
                in_side.b      = pose_y;
                in_side.base_x = '0;
                in_side.base_y = '0;
                in_side.angle  = -pose_angle;
            end
            OP_POINT:
            begin
                in_side.a      = other_x;
                in_side.b      = other_y;
                in_side.base_x = pose_x;
                in_side.base_y = pose_y;
                in_side.angle  = '0;
            end
            default:
            begin
                in_side.a      = '0;
                in_side.b      = '0;
                in_side.base_x = '0;
                in_side.base_y = '0;
                in_side.angle  = '0;
            end
        endcase
    end

    // Cosine and sine of the base heading.
    se2pt_cordic #(
        .ANGLE_BITS (ANGLE_BITS),
        .SIDE_W     (SIDE_W)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s_axis_tvalid),
        .angle     (pose_angle),
        .in_side   (in_side),
        .out_valid (cs_valid),
        .cos_val   (cos_val),
        .sin_val   (sin_val),
        .out_side  (cs_side_bits)
    );

    assign cs_side = side_t'(cs_side_bits);

    // Split the operands so that each product is at most (L + 1) by CS_W bits (17 by 33 by default).
    always_comb
    begin
        a_hi = coef_side_reg.a[COORD_BITS-1:L];
        b_hi = coef_side_reg.b[COORD_BITS-1:L];
        a_lo = $signed({1'b0, coef_side_reg.a[L-1:0]});
        b_lo = $signed({1'b0, coef_side_reg.b[L-1:0]});
    end

    // Valid bits of the stages after the CORDIC.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_valid_reg <= 1'b0;
            mul_valid_reg  <= 1'b0;
            sum_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else if (advance)
        begin
            coef_valid_reg <= cs_valid;
            mul_valid_reg  <= coef_valid_reg;
            sum_valid_reg  <= mul_valid_reg;
            m_valid_reg    <= sum_valid_reg;
        end
    end

    // Coefficients: x uses (c, -s), y uses (s, c); inversion negates c and
    // rotates the base translation instead of the second pose.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            coef_side_reg <= cs_side;
            kc_reg        <= cs_side.invert ? -cos_val : cos_val;
            ks_reg        <= sin_val;
            kns_reg       <= -sin_val;
        end
    end

    // Partial products.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mul_side_reg <= coef_side_reg;
            px_ah_reg    <= a_hi * kc_reg;
            px_al_reg    <= a_lo * kc_reg;
            px_bh_reg    <= b_hi * kns_reg;
            px_bl_reg    <= b_lo * kns_reg;
            py_ah_reg    <= a_hi * ks_reg;
            py_al_reg    <= a_lo * ks_reg;
            py_bh_reg    <= b_hi * kc_reg;
            py_bl_reg    <= b_lo * kc_reg;
        end
    end

    // High and low partial sums; the translation joins the high sum.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_side_reg <= mul_side_reg;
            hi_x_reg     <= HI_W'(px_ah_reg) + HI_W'(px_bh_reg)
                            + (HI_W'(mul_side_reg.base_x) <<< (ROUND_SHIFT - L));
            hi_y_reg     <= HI_W'(py_ah_reg) + HI_W'(py_bh_reg)
                            + (HI_W'(mul_side_reg.base_y) <<< (ROUND_SHIFT - L));
            lo_x_reg     <= LO_W'(px_al_reg) + LO_W'(px_bl_reg);
            lo_y_reg     <= LO_W'(py_al_reg) + LO_W'(py_bl_reg);
        end
    end

    // Recombine, round half up and clip.
    always_comb
    begin
        tot_x  = (TOT_W'(hi_x_reg) <<< L) + TOT_W'(lo_x_reg) + ROUND_HALF;
        tot_y  = (TOT_W'(hi_y_reg) <<< L) + TOT_W'(lo_y_reg) + ROUND_HALF;
        clip_x = clip_q(tot_x[TOT_W-1:ROUND_SHIFT]);
        clip_y = clip_q(tot_y[TOT_W-1:ROUND_SHIFT]);
    end

    // Output register; op code OP_NONE gives an all-zero result.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (sum_side_reg.none)
            begin
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_angle_reg <= '0;
                sat_reg       <= 1'b0;
            end
            else
            begin
                out_x_reg     <= clip_x[COORD_BITS-1:0];
                out_y_reg     <= clip_y[COORD_BITS-1:0];
                out_angle_reg <= sum_side_reg.angle;
                sat_reg       <= clip_x[COORD_BITS] | clip_y[COORD_BITS];
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_angle_reg, out_y_reg, out_x_reg});
    assign m_axis_tuser  = sat_reg;

endmodule

/* sv/se2pt_checker.sv */
`include "se2_pose_transform_unit_defines.svh"

module se2pt_checker #(
    parameter int COORD_BITS = se2pt_pkg::DEF_COORD_BITS,
    parameter int ANGLE_BITS = se2pt_pkg::DEF_ANGLE_BITS,
    parameter int OUT_W      = ((2 * COORD_BITS + ANGLE_BITS + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic [0:0]       m_axis_tuser
);
    localparam logic [COORD_BITS-1:0] POS_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
    localparam logic [COORD_BITS-1:0] POS_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

    logic [COORD_BITS-1:0] res_x;
    logic [COORD_BITS-1:0] res_y;

    assign res_x   = m_axis_tdata[COORD_BITS-1:0];
    assign res_y   = m_axis_tdata[2*COORD_BITS-1:COORD_BITS];

    // The input side is stalled exactly while a result waits.
    `SE2PT_ASSERT(a_ready_tracks_output, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "s_axis_tready does not follow the output stall")

    // A waiting result stays put until it is taken.
    `SE2PT_ASSERT(a_output_held, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // A clipped result shows a range limit on at least one axis.
    `SE2PT_ASSERT(a_sat_at_limit, m_axis_tvalid && m_axis_tuser[0] |-> res_x == POS_MAX || res_x == POS_MIN || res_y == POS_MAX || res_y == POS_MIN, "saturated flag without a clipped position")

    // Nothing is presented at the first edge after reset lets go.
    `SE2PT_ASSERT_ALWAYS(a_reset_quiet, $rose(rst_n) |-> !m_axis_tvalid, "output valid right after reset")

endmodule

bind se2_pose_transform_unit se2pt_checker #(
    .COORD_BITS (COORD_BITS),
    .ANGLE_BITS (ANGLE_BITS),
    .OUT_W      (OUT_W)
) u_se2pt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* test/se2pt_pose_checker.sv */
`timescale 1ns / 1ps

module se2pt_pose_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // pose_x, pose_y, pose_angle, other_x, other_y, other_angle
    input  logic [159:0] s_tdata,
    // op
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_angle
    input  logic [79:0]  m_tdata,
    // saturated
    input  logic [0:0]   m_tuser,
    output int           mismatches,
    output int           outstanding
);
    import se2pt_pkg::*;

    // One transformed pose as it leaves the block.
    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] heading;
        logic        clipped;
    } pose_result_t;

    localparam longint ROTATOR_GAIN = 64'sd652032874;

    // Arctangent of 2^-i in 32-bit binary angle units.
    localparam longint ATAN_STEP [30] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
    };

    pose_result_t pending_poses[$];
    int           fail_total = 0;
    int           queue_depth = 0;

    assign mismatches  = fail_total;
    assign outstanding = queue_depth;

    // Cosine and sine of a heading in Q2.30. Headings in the second and third
    // quadrants are turned by half a circle first and the results negated.
    function automatic void pose_sin_cos(input logic [15:0] heading,
                                         output longint cs, output longint sn);
        logic [31:0] turn;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      nx;
        turn = {heading, 16'h0000};
        flip = (turn[31:30] == 2'd1) || (turn[31:30] == 2'd2);
        if (flip)
            turn = turn + 32'h8000_0000;
        z = longint'($signed(turn));
        x = ROTATOR_GAIN;
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_STEP[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_STEP[i];
            end
            x = nx;
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    // Exact a*ka + b*kb + base*2^30, rounded to nearest (halves up) back to
    // the position format.
    function automatic longint rotate_round(input longint a, input longint ka,
                                            input longint b, input longint kb,
                                            input longint base);
        logic signed [95:0] acc;
        logic signed [95:0] wa;
        logic signed [95:0] wka;
        logic signed [95:0] wb;
        logic signed [95:0] wkb;
        logic signed [95:0] wbase;
        wa    = a;
        wka   = ka;
        wb    = b;
        wkb   = kb;
        wbase = base;
        acc = wa * wka + wb * wkb + (wbase <<< 30) + (96'sd1 <<< 29);
        acc = acc >>> 30;
        return longint'(acc[63:0]);
    endfunction

    // Clip to the signed 32-bit range and flag when clipping happened.
    function automatic logic [31:0] clamp_coord(input longint v, output logic hit);
        hit = 1'b0;
        if (v > 64'sd2147483647)
        begin
            hit = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            hit = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic pose_result_t transform_pose(input logic [1:0] op,
                                                    input logic [31:0] px,
                                                    input logic [31:0] py,
                                                    input logic [15:0] pa,
                                                    input logic [31:0] ox,
                                                    input logic [31:0] oy,
                                                    input logic [15:0] oa);
        pose_result_t r;
        longint       c;
        longint       s;
        longint       bx;
        longint       by;
        longint       qx;
        longint       qy;
        longint       rx;
        longint       ry;
        logic         hit_x;
        logic         hit_y;
        r = '0;
        if (op == OP_NONE)
            return r;
        pose_sin_cos(pa, c, s);
        bx = longint'($signed(px));
        by = longint'($signed(py));
        qx = longint'($signed(ox));
        qy = longint'($signed(oy));
        if (op == OP_INVERT)
        begin
            rx = rotate_round(bx, -c, by, -s, 0);
            ry = rotate_round(bx, s, by, -c, 0);
            r.heading = 16'h0000 - pa;
        end
        else
        begin
            rx = rotate_round(qx, c, qy, -s, bx);
            ry = rotate_round(qx, s, qy, c, by);
            r.heading = (op == OP_COMPOSE) ? pa + oa : 16'h0000;
        end
        r.pos_x   = clamp_coord(rx, hit_x);
        r.pos_y   = clamp_coord(ry, hit_y);
        r.clipped = hit_x | hit_y;
        return r;
    endfunction

    // Compare each output transfer with the oldest prediction, then queue the
    // prediction for the input transfer of the same edge.
    always @(posedge clk)
    begin
        pose_result_t want;
        pose_result_t got;
        int           bad;
        bad = 0;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.pos_x   = m_tdata[31:0];
                got.pos_y   = m_tdata[63:32];
                got.heading = m_tdata[79:64];
                got.clipped = m_tuser[0];
                if (pending_poses.size() == 0)
                begin
                    $display("%0t: unexpected result x=%h y=%h angle=%h sat=%b",
                             $time, got.pos_x, got.pos_y, got.heading, got.clipped);
                    bad++;
                end
                else
                begin
                    want = pending_poses.pop_front();
                    if (got.pos_x !== want.pos_x)
                    begin
                        $display("%0t: out_x expected %h actual %h",
                                 $time, want.pos_x, got.pos_x);
                        bad++;
                    end
                    if (got.pos_y !== want.pos_y)
                    begin
                        $display("%0t: out_y expected %h actual %h",
                                 $time, want.pos_y, got.pos_y);
                        bad++;
                    end
                    if (got.heading !== want.heading)
                    begin
                        $display("%0t: out_angle expected %h actual %h",
                                 $time, want.heading, got.heading);
                        bad++;
                    end
                    if (got.clipped !== want.clipped)
                    begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, want.clipped, got.clipped);
                        bad++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_poses.push_back(transform_pose(s_tuser,
                    s_tdata[31:0], s_tdata[63:32], s_tdata[79:64],
                    s_tdata[111:80], s_tdata[143:112], s_tdata[159:144]));
        end
        fail_total  <= fail_total + bad;
        queue_depth <= pending_poses.size();
    end

endmodule

/* test/tb_se2_pose_transform_unit.sv */
`timescale 1ns / 1ps

module tb_se2_pose_transform_unit;
    import se2pt_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int PHASE_ITEMS   = 300;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // pose_x, pose_y, pose_angle, other_x, other_y, other_angle
    logic [159:0] s_axis_tdata = '0;
    // op
    logic [1:0]   s_axis_tuser = OP_COMPOSE;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // out_x, out_y, out_angle
    logic [79:0]  m_axis_tdata;
    // saturated
    logic [0:0]   m_axis_tuser;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int source_idle = 35;
    int sink_idle   = 46;

    always #6 clk = ~clk;

    se2_pose_transform_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    se2pt_pose_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .s_tuser     (s_axis_tuser),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tuser     (m_axis_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Random backpressure on the result side.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle);

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_se2_pose_transform_unit: errors");
            $finish;
        end
    end

    // Present one pose pair after a random gap and hold it until the transfer.
    task automatic send_pose(input logic [1:0] op,
                             input logic [31:0] px, input logic [31:0] py,
                             input logic [15:0] pa,
                             input logic [31:0] ox, input logic [31:0] oy,
                             input logic [15:0] oa);
        while ($urandom_range(0, 99) < source_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {oa, oy, ox, pa, py, px};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Positions: full range, small, medium and the extremes.
    function automatic logic [31:0] pick_coord();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 4))
            0, 1:    return r;
            2:       return {{12{r[19]}}, r[19:0]};
            3:       return {{4{r[27]}}, r[27:0]};
            default:
            begin
                case (r[1:0])
                    2'd0:    return 32'h7FFF_FFFF;
                    2'd1:    return 32'h8000_0000;
                    2'd2:    return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    // Headings: full range, or close to a quadrant boundary.
    function automatic logic [15:0] pick_heading();
        logic [15:0] corner;
        if ($urandom_range(0, 1) == 0)
            return 16'($urandom());
        corner = 16'($urandom_range(0, 3)) << 14;
        return corner + 16'($urandom_range(0, 4)) - 16'd2;
    endfunction

    function automatic logic [1:0] pick_op();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 3)
            return OP_COMPOSE;
        else if (roll < 6)
            return OP_INVERT;
        else if (roll < 9)
            return OP_POINT;
        else
            return OP_NONE;
    endfunction

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed items: field extremes, every op, quadrant edges, clipping.
        send_pose(OP_COMPOSE, 32'h0, 32'h0, 16'h0000, 32'h0, 32'h0, 16'h0000);
        send_pose(OP_COMPOSE, 32'h0001_0000, 32'h0002_0000, 16'h4000,
                  32'h0001_0000, 32'h0, 16'h1000);
        send_pose(OP_COMPOSE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000);
        send_pose(OP_COMPOSE, 32'h8000_0000, 32'h8000_0000, 16'h0000,
                  32'h8000_0000, 32'h8000_0000, 16'h0000);
        send_pose(OP_COMPOSE, 32'h1234_5678, 32'hFEDC_BA98, 16'hFFFF,
                  32'h0000_8000, 32'hFFFF_8000, 16'h0002);
        send_pose(OP_COMPOSE, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        send_pose(OP_INVERT, 32'h8000_0000, 32'h0, 16'h0000,
                  32'h0, 32'h0, 16'h0000);
        send_pose(OP_INVERT, 32'h8000_0000, 32'h8000_0000, 16'h8000,
                  32'h0, 32'h0, 16'h0000);
        send_pose(OP_INVERT, 32'h8000_0000, 32'h8000_0000, 16'h2000,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_pose(OP_INVERT, 32'h0003_0000, 32'hFFFD_0000, 16'hC000,
                  32'h5555_5555, 32'hAAAA_AAAA, 16'h5A5A);
        send_pose(OP_INVERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0001,
                  32'h0, 32'h0, 16'h0000);
        send_pose(OP_POINT, 32'h0001_0000, 32'h0, 16'h4000,
                  32'h0001_0000, 32'h0001_0000, 16'hBEEF);
        send_pose(OP_POINT, 32'h0, 32'h0, 16'h3FFF,
                  32'h0010_0000, 32'hFFF0_0000, 16'h0000);
        send_pose(OP_POINT, 32'h0, 32'h0, 16'h4001,
                  32'h0010_0000, 32'hFFF0_0000, 16'h0000);
        send_pose(OP_POINT, 32'h0, 32'h0, 16'hBFFF,
                  32'h0010_0000, 32'hFFF0_0000, 16'h0000);
        send_pose(OP_POINT, 32'h0, 32'h0, 16'hC001,
                  32'h0010_0000, 32'hFFF0_0000, 16'h0000);
        send_pose(OP_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000,
                  32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        send_pose(OP_POINT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_pose(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_pose(OP_NONE, 32'h0, 32'h0, 16'h0000, 32'h0, 32'h0, 16'h0000);

        // Random items in three idling phases.
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                source_idle = 46;
                sink_idle   = 35;
            end
            else if (phase == 2)
            begin
                source_idle = 0;
                sink_idle   = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_pose(pick_op(), pick_coord(), pick_coord(), pick_heading(),
                          pick_coord(), pick_coord(), pick_heading());
        end
        s_axis_tvalid <= 1'b0;

        // Drain the pipeline.
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_se2_pose_transform_unit: clean");
        else
            $display("tb_se2_pose_transform_unit: errors");
        $finish;
    end

endmodule
